### hw/rtl/mp2s_pkg.sv
// Package with the shared constants and types of the 2x2 max pooling stream core.
`default_nettype none
package mp2s_pkg;

  localparam int unsigned MAX_COLS     = 32;
  localparam int unsigned MAX_ROWS     = 32;
  localparam int unsigned MAX_CHANNELS = 64;

  localparam int unsigned COL_W   = $clog2(MAX_COLS);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned CHAN_W  = $clog2(MAX_CHANNELS);
  localparam int unsigned ADDR_W  = COL_W + CHAN_W;
  localparam int unsigned DEPTH   = MAX_COLS * MAX_CHANNELS;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COLS_REG_W = 6;
  localparam int unsigned ROWS_REG_W = 6;
  localparam int unsigned CHAN_REG_W = 7;
  localparam int unsigned POS_OUT_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS_IN_USE     = 2'd0,
    CFG_ROWS_IN_USE     = 2'd1,
    CFG_CHANNELS_IN_USE = 2'd2
  } cfg_index_t;

  typedef logic signed [VALUE_W-1:0] value_t;

endpackage
`default_nettype wire

### hw/rtl/mp2s_in_if.sv
// Interface for the sample request channel into the pooling core.
`default_nettype none
interface mp2s_in_if;
  logic                   valid;
  logic                   ready;
  mp2s_pkg::value_t       sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/mp2s_out_if.sv
// Interface for the pooled result request channel out of the pooling core.
`default_nettype none
interface mp2s_out_if;
  logic                   valid;
  logic                   ready;
  mp2s_pkg::value_t       pooled_value;
  logic [5:0]             channel_index;
  logic [3:0]             out_row;
  logic [3:0]             out_col;
  logic                   last_channel;
  logic                   frame_end;

  modport source (
    output valid, output pooled_value, output channel_index, output out_row,
    output out_col, output last_channel, output frame_end, input ready
  );
  modport sink (
    input valid, input pooled_value, input channel_index, input out_row,
    input out_col, input last_channel, input frame_end, output ready
  );
endinterface
`default_nettype wire

### hw/rtl/max_pool_2x2_stream_core.sv
// Top level of the 2x2 stride-2 max pooling core for an interleaved feature stream.
// A result passes through the stage-1 registers and then the output register after its
// sample is accepted. Throughput: one sample per cycle while the output is not stalled;
// the line store takes one read per sample and one write per even-row sample.
// Reset: synchronous active-low reset clears counters, valid flags and configuration
// (24 columns, 24 rows, 20 channels); the line store and pair maxima are not cleared.
`default_nettype none
module max_pool_2x2_stream_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [mp2s_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [mp2s_pkg::CFG_DATA_W-1:0]    cfg_data,
  mp2s_in_if.sink                           in_stream,
  mp2s_out_if.source                        out_stream
);
  import mp2s_pkg::*;

  logic [COLS_REG_W-1:0] cols_r;
  logic [ROWS_REG_W-1:0] rows_r;
  logic [CHAN_REG_W-1:0] chans_r;

  logic [COLS_REG_W-1:0] ncols;
  logic [ROWS_REG_W-1:0] nrows;
  logic [CHAN_REG_W-1:0] nch;

  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [CHAN_W-1:0] chan_r;

  logic [ADDR_W-1:0] addr;
  logic              accept;
  logic              last_ch;
  logic              last_row;
  logic              last_col;

  value_t            line_mem [DEPTH];
  value_t            pair_mem [MAX_CHANNELS];

  logic              s1_v_r;
  value_t            s1_val_r;
  value_t            s1_top_r;
  value_t            s1_pm_mem_r;
  value_t            s1_pm_byp_r;
  logic              s1_pm_hit_r;
  logic              s1_row_odd_r;
  logic              s1_col_odd_r;
  logic [CHAN_W-1:0] s1_ch_r;
  logic [POS_OUT_W-1:0] s1_orow_r;
  logic [POS_OUT_W-1:0] s1_ocol_r;
  logic              s1_last_ch_r;
  logic              s1_frame_end_r;

  logic              s1_emit;
  logic              s1_pair_wr;
  logic              s1_adv;
  value_t            s1_m1;
  value_t            s1_m2;
  value_t            s1_pm;

  logic              out_v_r;
  value_t            out_val_r;
  logic [CHAN_W-1:0] out_ch_r;
  logic [POS_OUT_W-1:0] out_row_r;
  logic [POS_OUT_W-1:0] out_col_r;
  logic              out_last_ch_r;
  logic              out_frame_end_r;

  // Effective dimensions: zero acts as one, values above the maximum clamp.
  always_comb begin
    if (cols_r == '0) begin
      ncols = COLS_REG_W'(1);
    end else if (cols_r > COLS_REG_W'(MAX_COLS)) begin
      ncols = COLS_REG_W'(MAX_COLS);
    end else begin
      ncols = cols_r;
    end
    if (rows_r == '0) begin
      nrows = ROWS_REG_W'(1);
    end else if (rows_r > ROWS_REG_W'(MAX_ROWS)) begin
      nrows = ROWS_REG_W'(MAX_ROWS);
    end else begin
      nrows = rows_r;
    end
    if (chans_r == '0) begin
      nch = CHAN_REG_W'(1);
    end else if (chans_r > CHAN_REG_W'(MAX_CHANNELS)) begin
      nch = CHAN_REG_W'(MAX_CHANNELS);
    end else begin
      nch = chans_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= COLS_REG_W'(24);
      rows_r  <= ROWS_REG_W'(24);
      chans_r <= CHAN_REG_W'(20);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS_IN_USE:     cols_r  <= cfg_data[COLS_REG_W-1:0];
        CFG_ROWS_IN_USE:     rows_r  <= cfg_data[ROWS_REG_W-1:0];
        CFG_CHANNELS_IN_USE: chans_r <= cfg_data[CHAN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_emit    = s1_row_odd_r && s1_col_odd_r;
  assign s1_pair_wr = s1_row_odd_r && !s1_col_odd_r;
  assign s1_adv     = s1_v_r && (!s1_emit || !out_v_r || out_stream.ready);
  assign in_stream.ready = !s1_v_r || s1_adv;
  assign accept     = in_stream.valid && in_stream.ready;
  assign addr       = {col_r, chan_r};

  assign last_ch  = ({1'b0, chan_r} + CHAN_REG_W'(1)) >= nch;
  assign last_col = ({2'b0, col_r} + 7'd3) > {1'b0, ncols};
  assign last_row = ({2'b0, row_r} + 7'd3) > {1'b0, nrows};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      chan_r <= '0;
    end else if (accept) begin
      if (last_ch) begin
        chan_r <= '0;
        if (({1'b0, col_r} + COLS_REG_W'(1)) >= ncols) begin
          col_r <= '0;
          if (({1'b0, row_r} + ROWS_REG_W'(1)) >= nrows) begin
            row_r <= '0;
          end else begin
            row_r <= row_r + ROW_W'(1);
          end
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end else begin
        chan_r <= chan_r + CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !row_r[0]) begin
      line_mem[addr] <= in_stream.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_top_r <= line_mem[addr];
    end
  end

  always_comb begin
    s1_pm = s1_pm_hit_r ? s1_pm_byp_r : s1_pm_mem_r;
    s1_m1 = (s1_top_r > s1_val_r) ? s1_top_r : s1_val_r;
    s1_m2 = (s1_pm > s1_m1) ? s1_pm : s1_m1;
  end

  // A pair maximum written in the same cycle as its read is taken from the bypass register.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_pair_wr) begin
      pair_mem[s1_ch_r] <= s1_m1;
    end
    if (accept) begin
      s1_pm_mem_r <= pair_mem[chan_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_val_r       <= in_stream.sample_value;
      s1_pm_hit_r    <= s1_adv && s1_pair_wr && (s1_ch_r == chan_r);
      s1_pm_byp_r    <= s1_m1;
      s1_row_odd_r   <= row_r[0];
      s1_col_odd_r   <= col_r[0];
      s1_ch_r        <= chan_r;
      s1_orow_r      <= row_r[POS_OUT_W:1];
      s1_ocol_r      <= col_r[POS_OUT_W:1];
      s1_last_ch_r   <= last_ch;
      s1_frame_end_r <= last_ch && last_row && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_v_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_val_r       <= s1_m2;
      out_ch_r        <= s1_ch_r;
      out_row_r       <= s1_orow_r;
      out_col_r       <= s1_ocol_r;
      out_last_ch_r   <= s1_last_ch_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_stream.valid         = out_v_r;
  assign out_stream.pooled_value  = out_val_r;
  assign out_stream.channel_index = out_ch_r;
  assign out_stream.out_row       = out_row_r;
  assign out_stream.out_col       = out_col_r;
  assign out_stream.last_channel  = out_last_ch_r;
  assign out_stream.frame_end     = out_frame_end_r;

endmodule
`default_nettype wire
